FILE: src/mrta_pkg.sv
// Shared types and constants of the Modbus register table access block.
// Used by mrta_ctrl, mrta_dp and modbus_register_table_access.
`default_nettype none

package mrta_pkg;

    // Table depths and the index widths that follow from them.
    localparam int INPUT_DEPTH   = 64;
    localparam int HOLDING_DEPTH = 64;
    localparam int INPUT_AW      = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
    localparam int HOLDING_AW    = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;

    // Request types carried by each word.
    localparam logic [1:0] REQ_READ_INPUT    = 2'd0;
    localparam logic [1:0] REQ_READ_HOLDING  = 2'd1;
    localparam logic [1:0] REQ_WRITE_HOLDING = 2'd2;
    localparam logic [1:0] REQ_WRITE_INPUT   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_INPUT_BASE    = 3'd0;
    localparam logic [2:0] CFG_INPUT_USED    = 3'd1;
    localparam logic [2:0] CFG_HOLDING_BASE  = 3'd2;
    localparam logic [2:0] CFG_HOLDING_USED  = 3'd3;
    localparam logic [2:0] CFG_NOTIFY_ENABLE = 3'd4;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ACCESS,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic access;
        logic finish;
    } dp_cmd_t;

endpackage

`default_nettype wire

FILE: src/mrta_ctrl.sv
// Controller of the register table access block: sequences one word through
// check, table access and result. Depends on mrta_pkg.
`default_nettype none

module mrta_ctrl
    import mrta_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result register can take a new word when empty or being emptied.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A finished word sets the flag; a taken word clears it.
    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/mrta_dp.sv
// Datapath of the register table access block: configuration registers,
// window check, both register tables and the result register. Depends on mrta_pkg.
`default_nettype none

module mrta_dp
    import mrta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] start_address,
    input  wire logic [6:0]  reg_count,
    input  wire logic [15:0] word_data,
    input  wire logic        burst_first,
    output logic [15:0]      read_word,
    output logic             status,
    output logic             burst_done,
    output logic             update_valid,
    output logic [15:0]      update_address,
    output logic [6:0]       update_count
);

    // Configuration registers.
    logic [15:0] input_base_reg;
    logic [6:0]  input_used_reg;
    logic [15:0] holding_base_reg;
    logic [6:0]  holding_used_reg;
    logic        notify_enable_reg;

    // Burst position, kept across words.
    logic [6:0]  pos_reg;
    logic [6:0]  pos_next;

    // Captured word.
    logic [1:0]  type_reg;
    logic [15:0] start_reg;
    logic [6:0]  count_reg;
    logic [15:0] data_reg;

    // Check results.
    logic        ok_reg;
    logic [15:0] first_reg;
    logic        in_burst_reg;
    logic        last_reg;
    logic        done_reg;
    logic [15:0] addr_reg;

    // Access results.
    logic        rd_input_reg;
    logic        rd_holding_reg;
    logic [15:0] in_rdata_reg;
    logic [15:0] hold_rdata_reg;
    logic        in_rvalid_reg;
    logic        hold_rvalid_reg;

    // Result register.
    logic [15:0] read_word_reg;
    logic        status_reg;
    logic        burst_done_reg;
    logic        update_valid_reg;
    logic [15:0] update_address_reg;
    logic [6:0]  update_count_reg;

    // Tables and their written marks.
    logic [15:0] input_mem   [INPUT_DEPTH];
    logic [15:0] holding_mem [HOLDING_DEPTH];
    logic [INPUT_DEPTH-1:0]   input_vld_reg;
    logic [HOLDING_DEPTH-1:0] holding_vld_reg;

    // Check logic.
    logic        on_input;
    logic [15:0] addr;
    logic [15:0] base;
    logic [16:0] used17;
    logic [16:0] depth17;
    logic [16:0] lim17;
    logic        ok;
    logic [7:0]  pos_inc;

    // Access logic.
    logic                  type_on_input;
    logic [16:0]           idx;
    logic                  hit_input;
    logic                  hit_holding;
    logic [INPUT_AW-1:0]   in_idx;
    logic [HOLDING_AW-1:0] hold_idx;
    logic                  wr_input;
    logic                  wr_holding;
    logic                  upd;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_base_reg    <= 16'd0;
            input_used_reg    <= 7'd64;
            holding_base_reg  <= 16'd0;
            holding_used_reg  <= 7'd64;
            notify_enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_INPUT_BASE:    input_base_reg    <= cfg_data;
                CFG_INPUT_USED:    input_used_reg    <= cfg_data[6:0];
                CFG_HOLDING_BASE:  holding_base_reg  <= cfg_data;
                CFG_HOLDING_USED:  holding_used_reg  <= cfg_data[6:0];
                CFG_NOTIFY_ENABLE: notify_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Position restarts on the first word and saturates past the end.
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.load && burst_first)
            pos_next = 7'd0;
        else if (cmd.finish && pos_reg != 7'd127)
            pos_next = pos_reg + 7'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= 7'd0;
        else
            pos_reg <= pos_next;
    end

    // Capture the accepted word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg  <= req_type;
            start_reg <= start_address;
            count_reg <= reg_count;
            data_reg  <= word_data;
        end
    end

    // Window check: the burst must start at or above the base and end
    // within base plus the used count clipped to the table depth.
    assign type_on_input = (type_reg == REQ_READ_INPUT) || (type_reg == REQ_WRITE_INPUT);
    assign on_input      = type_on_input;
    assign addr          = start_reg - 16'd1;
    assign base          = on_input ? input_base_reg : holding_base_reg;
    assign used17        = {10'd0, on_input ? input_used_reg : holding_used_reg};
    assign depth17       = on_input ? 17'(INPUT_DEPTH) : 17'(HOLDING_DEPTH);
    assign lim17         = (used17 < depth17) ? used17 : depth17;
    assign ok            = (addr >= base) &&
                           (({1'b0, addr} + {10'd0, count_reg}) <= ({1'b0, base} + lim17));
    assign pos_inc       = {1'b0, pos_reg} + 8'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            ok_reg       <= ok;
            first_reg    <= addr - base;
            in_burst_reg <= pos_reg < count_reg;
            last_reg     <= (count_reg == 7'd0) ? (pos_reg == 7'd0) : (pos_inc == {1'b0, count_reg});
            done_reg     <= pos_inc >= {1'b0, count_reg};
            addr_reg     <= addr;
        end
    end

    // Table access at the burst position.
    assign idx         = {1'b0, first_reg} + {10'd0, pos_reg};
    assign hit_input   = ok_reg && in_burst_reg && type_on_input && (idx < 17'(INPUT_DEPTH));
    assign hit_holding = ok_reg && in_burst_reg && !type_on_input &&
                         (idx < 17'(HOLDING_DEPTH));
    assign in_idx      = idx[INPUT_AW-1:0];
    assign hold_idx    = idx[HOLDING_AW-1:0];
    assign wr_input    = cmd.access && hit_input && (type_reg == REQ_WRITE_INPUT);
    assign wr_holding  = cmd.access && hit_holding && (type_reg == REQ_WRITE_HOLDING);

    // Input table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_input)
            input_mem[in_idx] <= data_reg;
        if (cmd.access)
            in_rdata_reg <= input_mem[in_idx];
    end

    // Holding table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_holding)
            holding_mem[hold_idx] <= data_reg;
        if (cmd.access)
            hold_rdata_reg <= holding_mem[hold_idx];
    end

    // Written marks: an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_vld_reg   <= '0;
            holding_vld_reg <= '0;
        end
        else
        begin
            if (wr_input)
                input_vld_reg[in_idx] <= 1'b1;
            if (wr_holding)
                holding_vld_reg[hold_idx] <= 1'b1;
        end
    end

    // Read selection registered with the data.
    always_ff @(posedge clk)
    begin
        if (cmd.access)
        begin
            rd_input_reg    <= hit_input && (type_reg == REQ_READ_INPUT);
            rd_holding_reg  <= hit_holding && (type_reg == REQ_READ_HOLDING);
            in_rvalid_reg   <= input_vld_reg[in_idx];
            hold_rvalid_reg <= holding_vld_reg[hold_idx];
        end
    end

    // Result word.
    assign upd = ok_reg && (type_reg == REQ_WRITE_HOLDING) && notify_enable_reg && last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (rd_input_reg && in_rvalid_reg)
                read_word_reg <= in_rdata_reg;
            else if (rd_holding_reg && hold_rvalid_reg)
                read_word_reg <= hold_rdata_reg;
            else
                read_word_reg <= 16'd0;
            status_reg         <= !ok_reg;
            burst_done_reg     <= done_reg;
            update_valid_reg   <= upd;
            update_address_reg <= upd ? addr_reg : 16'd0;
            update_count_reg   <= upd ? count_reg : 7'd0;
        end
    end

    assign read_word      = read_word_reg;
    assign status         = status_reg;
    assign burst_done     = burst_done_reg;
    assign update_valid   = update_valid_reg;
    assign update_address = update_address_reg;
    assign update_count   = update_count_reg;

endmodule

`default_nettype wire

FILE: src/modbus_register_table_access.sv
// Top level of the Modbus register table access block.
// Depends on mrta_pkg, mrta_ctrl and mrta_dp.
//
//   Channel   Handshake                 Moves
//   in        in_valid / in_ready       one request word of a burst
//   out       out_valid / out_ready     one result word
//   cfg       cfg_write_en              one register write, no wait
//
// A word passes capture, window check, registered table read or write, and
// loading of the result register before the next word is accepted. The
// check compare and the table read are both registered.
// A result that is not taken holds the controller after the table access until
// the result register frees; the next word is accepted while a result waits.
// Reset is asynchronous and active low; the tables read as zero after reset
// through per-entry written marks, so no clearing pass is needed.
`default_nettype none

module modbus_register_table_access
    import mrta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] start_address,
    input  wire logic [6:0]  reg_count,
    input  wire logic [15:0] word_data,
    input  wire logic        burst_first,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      read_word,
    output logic             status,
    output logic             burst_done,
    output logic             update_valid,
    output logic [15:0]      update_address,
    output logic [6:0]       update_count
);

    dp_cmd_t cmd;

    // Sequencer.
    mrta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Tables, check and result register.
    mrta_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .start_address  (start_address),
        .reg_count      (reg_count),
        .word_data      (word_data),
        .burst_first    (burst_first),
        .read_word      (read_word),
        .status         (status),
        .burst_done     (burst_done),
        .update_valid   (update_valid),
        .update_address (update_address),
        .update_count   (update_count)
    );

    // Only one word is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted while one is in work");

    // An update notice only comes with an in-window, last word.
    a_update_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && update_valid) |-> (!status && burst_done))
        else $error("update notice on a failed or unfinished burst");

    // A failed check never returns table data.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (read_word == 16'd0 && !update_valid))
        else $error("data returned for a burst outside the window");

endmodule

`default_nettype wire

FILE: bench/modbus_register_table_access_test.sv
// Self-checking testbench for the Modbus register table access block.
// Depends on mrta_pkg and modbus_register_table_access; it compares every result word
// with a behavioral model of the two register tables kept inside this file.
`default_nettype none

module modbus_register_table_access_test;
    import mrta_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 150;
    localparam int CYCLE_LIMIT = 500000;
    localparam int POS_MAX     = 127;

    // One result word as the block presents it.
    typedef struct packed {
        logic [15:0] rd;
        logic        status;
        logic        done;
        logic        upd;
        logic [15:0] uaddr;
        logic [6:0]  ucnt;
    } result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    // One line of the directed table: a request word or a register write.
    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  sel;
        logic [15:0] start;
        logic [6:0]  cnt;
        logic [15:0] data;
        logic        first;
        logic        typed;
        result_t     res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [15:0] start_address;
    logic [6:0]  reg_count;
    logic [15:0] word_data;
    logic        burst_first;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] read_word;
    logic        status;
    logic        burst_done;
    logic        update_valid;
    logic [15:0] update_address;
    logic [6:0]  update_count;

    // Model of the register map: both tables, the burst position and the settings.
    logic [15:0] input_regs [INPUT_DEPTH];
    logic [15:0] holding_regs [HOLDING_DEPTH];
    logic [6:0]  burst_pos;
    logic [15:0] in_base;
    logic [6:0]  in_used;
    logic [15:0] hold_base;
    logic [6:0]  hold_used;
    logic        notify_on;

    result_t   pending_results [$];
    stim_row_t dir_rows [$];

    int bad_results;
    int results_seen;
    int window_errs;
    int notices;
    int words_sent;
    int bursts_sent;
    int regs_written;
    int burst_left;
    int stall_mode;
    int stall_left;
    int cycles;

    modbus_register_table_access uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .start_address  (start_address),
        .reg_count      (reg_count),
        .word_data      (word_data),
        .burst_first    (burst_first),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_word      (read_word),
        .status         (status),
        .burst_done     (burst_done),
        .update_valid   (update_valid),
        .update_address (update_address),
        .update_count   (update_count)
    );

    always #5 clk = ~clk;

    // Expected result of one word; updates the model tables and the burst position.
    function automatic result_t map_access(input logic [1:0] t, input logic [15:0] s,
            input logic [6:0] c, input logic [15:0] d, input logic f);
        result_t     r;
        logic [15:0] a16;
        int          a;
        int          base;
        int          lim;
        int          pos;
        int          idx;
        logic        on_in;
        logic        ok;
        logic        last;
        r = '0;
        if (f)
            burst_pos = '0;
        pos = burst_pos;
        // The one-based address wraps to 65535 when it is zero.
        a16 = s - 16'd1;
        a = a16;
        on_in = (t == REQ_READ_INPUT) || (t == REQ_WRITE_INPUT);
        base = on_in ? in_base : hold_base;
        lim = on_in ? in_used : hold_used;
        // A window wider than the table is cut to the table depth.
        if (on_in && lim > INPUT_DEPTH)
            lim = INPUT_DEPTH;
        if (!on_in && lim > HOLDING_DEPTH)
            lim = HOLDING_DEPTH;
        ok = (a >= base) && (a + c <= base + lim);
        last = (c == 0) ? (pos == 0) : (pos + 1 == c);
        idx = a - base + pos;
        if (ok && pos < c)
        begin
            case (t)
                REQ_READ_INPUT:
                    if (idx < INPUT_DEPTH)
                        r.rd = input_regs[idx];
                REQ_WRITE_INPUT:
                    if (idx < INPUT_DEPTH)
                        input_regs[idx] = d;
                REQ_READ_HOLDING:
                    if (idx < HOLDING_DEPTH)
                        r.rd = holding_regs[idx];
                default:
                    if (idx < HOLDING_DEPTH)
                        holding_regs[idx] = d;
            endcase
        end
        if (ok && t == REQ_WRITE_HOLDING && notify_on && last)
        begin
            r.upd = 1'b1;
            r.uaddr = a16;
            r.ucnt = c;
        end
        r.status = !ok;
        r.done = (pos + 1 >= c);
        if (burst_pos < POS_MAX)
            burst_pos = burst_pos + 7'd1;
        return r;
    endfunction

    task automatic word_row(input logic [1:0] t, input logic [15:0] s, input logic [6:0] c,
            input logic [15:0] d, input logic f);
        dir_rows.push_back('{ROW_WORD, {1'b0, t}, s, c, d, f, 1'b0, result_t'('0)});
    endtask

    // Rows with a typed result; all of them read back zero.
    task automatic fixed_row(input logic [1:0] t, input logic [15:0] s, input logic [6:0] c,
            input logic [15:0] d, input logic f, input logic st, input logic dn,
            input logic up, input logic [15:0] ua, input logic [6:0] uc);
        result_t r;
        r = '{16'h0000, st, dn, up, ua, uc};
        dir_rows.push_back('{ROW_WORD, {1'b0, t}, s, c, d, f, 1'b1, r});
    endtask

    task automatic reg_row(input logic [2:0] idx, input logic [15:0] v);
        dir_rows.push_back('{ROW_REG, idx, 16'h0, 7'd0, v, 1'b0, 1'b0, result_t'('0)});
    endtask

    // Register write at a falling edge; the caller lowers the enable afterwards.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_INPUT_BASE:   in_base = v;
            CFG_INPUT_USED:   in_used = v[6:0];
            CFG_HOLDING_BASE: hold_base = v;
            CFG_HOLDING_USED: hold_used = v[6:0];
            default:          notify_on = v[0];
        endcase
        regs_written++;
        @(negedge clk);
    endtask

    // Offer one word, wait for it to be taken, then maybe end the sender burst.
    task automatic send_word(input logic [1:0] t, input logic [15:0] s, input logic [6:0] c,
            input logic [15:0] d, input logic f, input logic typed, input result_t fixed);
        result_t r;
        r = map_access(t, s, c, d, f);
        pending_results.push_back(typed ? fixed : r);
        words_sent++;
        if (f)
            bursts_sent++;
        in_valid <= 1'b1;
        req_type <= t;
        start_address <= s;
        reg_count <= c;
        word_data <= d;
        burst_first <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Hold the sender until every expected word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: the stall pattern is redrawn from four modes when its countdown runs out.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_left % 8 != 0);
        endcase
    end

    // Result checker.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {read_word, status, burst_done, update_valid, update_address, update_count};
            results_seen++;
            if (got.status)
                window_errs++;
            if (got.upd)
                notices++;
            if (pending_results.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result %0d arrived with nothing expected: %h", results_seen, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                    begin
                        $display("result %0d expected rd %h st %b done %b upd %b addr %h cnt %0d",
                                 results_seen, want.rd, want.status, want.done, want.upd,
                                 want.uaddr, want.ucnt);
                        $display("  %0d got      rd %h st %b done %b upd %b addr %h cnt %0d",
                                 results_seen, got.rd, got.status, got.done, got.upd,
                                 got.uaddr, got.ucnt);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int          i;
        int          k;
        int          n;
        int          phase;
        int          target;
        int          lim;
        int          a;
        int          cnt_v;
        int          iu;
        int          hu;
        int          ib;
        int          hb;
        logic [1:0]  kind_v;
        logic [1:0]  t;
        logic [15:0] start_v;
        logic        f;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_READ_INPUT;
        start_address = '0;
        reg_count = '0;
        word_data = '0;
        burst_first = 1'b0;
        out_ready = 1'b0;
        stall_mode = 0;
        stall_left = 0;
        cycles = 0;
        bad_results = 0;
        results_seen = 0;
        window_errs = 0;
        notices = 0;
        words_sent = 0;
        bursts_sent = 0;
        regs_written = 0;
        burst_left = $urandom_range(1, 12);
        for (i = 0; i < INPUT_DEPTH; i++)
            input_regs[i] = '0;
        for (i = 0; i < HOLDING_DEPTH; i++)
            holding_regs[i] = '0;
        burst_pos = '0;
        in_base = 16'd0;
        in_used = 7'd64;
        hold_base = 16'd0;
        hold_used = 7'd64;
        notify_on = 1'b0;

        // Directed table. Reset settings first: untouched tables and window edges.
        fixed_row(REQ_READ_INPUT,    16'd1,     7'd1,  16'h0000, 1'b1, 0, 1, 0, 16'h0, 7'd0);
        fixed_row(REQ_READ_HOLDING,  16'd64,    7'd1,  16'h0000, 1'b1, 0, 1, 0, 16'h0, 7'd0);
        fixed_row(REQ_READ_INPUT,    16'd65,    7'd1,  16'h0000, 1'b1, 1, 1, 0, 16'h0, 7'd0);
        // Start address zero wraps out of a window based at zero.
        fixed_row(REQ_READ_HOLDING,  16'd0,     7'd1,  16'h0000, 1'b1, 1, 1, 0, 16'h0, 7'd0);
        word_row(REQ_WRITE_HOLDING,  16'd1,     7'd3,  16'hFFFF, 1'b1);
        word_row(REQ_WRITE_HOLDING,  16'd1,     7'd3,  16'h0000, 1'b0);
        word_row(REQ_WRITE_HOLDING,  16'd1,     7'd3,  16'hA5A5, 1'b0);
        word_row(REQ_READ_HOLDING,   16'd1,     7'd3,  16'h0000, 1'b1);
        word_row(REQ_READ_HOLDING,   16'd1,     7'd3,  16'h0000, 1'b0);
        word_row(REQ_READ_HOLDING,   16'd1,     7'd3,  16'h0000, 1'b0);
        // A word past the end of the burst touches nothing.
        fixed_row(REQ_READ_HOLDING,  16'd1,     7'd3,  16'h0000, 1'b0, 0, 1, 0, 16'h0, 7'd0);
        word_row(REQ_WRITE_INPUT,    16'd64,    7'd1,  16'h1234, 1'b1);
        word_row(REQ_READ_INPUT,     16'd64,    7'd1,  16'h0000, 1'b1);
        // Window at the top of the address space, with update notices on.
        reg_row(CFG_NOTIFY_ENABLE, 16'd1);
        reg_row(CFG_HOLDING_BASE,  16'd65500);
        fixed_row(REQ_WRITE_HOLDING, 16'd0,     7'd0,  16'h5A5A, 1'b1, 0, 1, 1, 16'hFFFF, 7'd0);
        word_row(REQ_WRITE_HOLDING,  16'd65501, 7'd64, 16'h8001, 1'b1);
        // Type and count change in the middle of a burst.
        word_row(REQ_READ_HOLDING,   16'd65501, 7'd64, 16'h0000, 1'b0);
        word_row(REQ_WRITE_HOLDING,  16'd65501, 7'd2,  16'h7FFE, 1'b0);
        word_row(REQ_WRITE_HOLDING,  16'd65502, 7'd2,  16'h1111, 1'b1);
        word_row(REQ_WRITE_HOLDING,  16'd65502, 7'd2,  16'h2222, 1'b0);
        reg_row(CFG_INPUT_BASE,    16'd65535);
        reg_row(CFG_INPUT_USED,    16'd1);
        word_row(REQ_READ_INPUT,     16'd0,     7'd1,  16'h0000, 1'b1);
        fixed_row(REQ_READ_INPUT,    16'd0,     7'd2,  16'h0000, 1'b1, 1, 0, 0, 16'h0, 7'd0);
        // Holding window wider than the table.
        reg_row(CFG_HOLDING_BASE,  16'd0);
        reg_row(CFG_HOLDING_USED,  16'd100);
        word_row(REQ_READ_HOLDING,   16'd64,    7'd1,  16'h0000, 1'b1);
        fixed_row(REQ_READ_HOLDING,  16'd65,    7'd1,  16'h0000, 1'b1, 1, 1, 0, 16'h0, 7'd0);
        // Empty input window: only a zero count at the base passes.
        reg_row(CFG_INPUT_USED,    16'd0);
        fixed_row(REQ_READ_INPUT,    16'd0,     7'd0,  16'h0000, 1'b1, 0, 1, 0, 16'h0, 7'd0);
        fixed_row(REQ_WRITE_INPUT,   16'd1,     7'd64, 16'hFFFF, 1'b1, 1, 0, 0, 16'h0, 7'd0);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                drain();
                write_reg(dir_rows[i].sel, dir_rows[i].data);
            end
            else
            begin
                cfg_write_en <= 1'b0;
                send_word(dir_rows[i].sel[1:0], dir_rows[i].start, dir_rows[i].cnt,
                          dir_rows[i].data, dir_rows[i].first, dir_rows[i].typed,
                          dir_rows[i].res);
            end
        end

        // Random phases, each with its own window settings.
        for (phase = 0; phase < PHASES; phase++)
        begin
            iu = (phase == 0 || phase == PHASES - 1) ? 64 :
                 (phase == 2) ? 0 : $urandom_range(1, 64);
            hu = (phase == 0 || phase == PHASES - 1) ? 64 :
                 (phase == 3) ? 1 : $urandom_range(1, 64);
            ib = (phase == 0) ? 0 : (phase == PHASES - 1) ? 65536 - iu :
                 $urandom_range(0, 65536 - iu);
            hb = (phase == 0) ? 0 : (phase == PHASES - 1) ? 65536 - hu :
                 $urandom_range(0, 65536 - hu);
            if (ib > 65535)
                ib = 65535;
            if (hb > 65535)
                hb = 65535;
            drain();
            write_reg(CFG_INPUT_BASE, ib[15:0]);
            write_reg(CFG_INPUT_USED, iu[15:0]);
            write_reg(CFG_HOLDING_BASE, hb[15:0]);
            write_reg(CFG_HOLDING_USED, hu[15:0]);
            write_reg(CFG_NOTIFY_ENABLE, (phase % 3 != 0) ? 16'd1 : 16'd0);
            cfg_write_en <= 1'b0;

            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
            begin
                // Now and then the sender waits for all results.
                if ($urandom_range(0, 99) == 0)
                    drain();
                kind_v = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 80)
                begin
                    // Well-formed burst inside the window, sometimes cut short or overrun.
                    if (kind_v == REQ_READ_INPUT || kind_v == REQ_WRITE_INPUT)
                    begin
                        lim = in_used;
                        a = in_base;
                    end
                    else
                    begin
                        lim = hold_used;
                        a = hold_base;
                    end
                    if (lim > INPUT_DEPTH)
                        lim = INPUT_DEPTH;
                    k = $urandom_range(0, 9);
                    if (lim == 0 || k == 0)
                        cnt_v = 0;
                    else if (k < 8)
                        cnt_v = $urandom_range(1, (lim < 8) ? lim : 8);
                    else
                        cnt_v = $urandom_range(1, lim);
                    a = a + $urandom_range(0, lim - cnt_v);
                    if (a > 65535)
                        a = 65535;
                    start_v = a[15:0] + 16'd1;
                    n = (cnt_v == 0) ? 1 : cnt_v;
                    if ($urandom_range(0, 9) == 0)
                        n = $urandom_range(1, n);
                    if ($urandom_range(0, 9) == 0)
                        n = n + $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                    begin
                        t = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : kind_v;
                        send_word(t, start_v, cnt_v[6:0], 16'($urandom_range(0, 65535)),
                                  k == 0, 1'b0, result_t'('0));
                    end
                end
                else
                begin
                    // Noise: arbitrary address and count, loose burst marks.
                    start_v = 16'($urandom_range(0, 65535));
                    cnt_v = $urandom_range(0, 64);
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++)
                    begin
                        f = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
                        send_word(kind_v, start_v, cnt_v[6:0], 16'($urandom_range(0, 65535)),
                                  f, 1'b0, result_t'('0));
                    end
                end
            end
        end

        drain();
        repeat (20) @(negedge clk);
        $display("ran %0d words in %0d bursts with %0d register writes over %0d phases",
                 words_sent, bursts_sent, regs_written, PHASES);
        $display("checked %0d results: %0d window errors, %0d update notices, %0d missing",
                 results_seen, window_errs, notices, pending_results.size());
        if (bad_results == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
